/* rtl/core/cmn_pkg.sv */
`timescale 1ns / 1ps

package cmn_pkg;

  // defaults for the top-level parameters
  localparam int PHASE_BITS_DEF      = 24;
  localparam int VALUE_FRAC_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAOS     = 2'd2;

  typedef enum logic {
    MODE_CLASSIC = 1'b0,
    MODE_BROKEN  = 1'b1
  } mode_t;

  localparam int INC_W     = 24;
  localparam int GAIN_W    = 15;
  localparam int GAIN_FRAC = 14;
  localparam int SAMPLE_W  = 15;

  localparam logic [INC_W-1:0]    PHASE_INC_RST = 24'd4194304;
  localparam logic [GAIN_W-1:0]   CHAOS_RST     = 15'd24576;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = 15'd32767;

  // integer part of the map values (Q3.f)
  localparam int VAL_INT_BITS = 3;

endpackage

/* rtl/core/cmn_map.sv */
`timescale 1ns / 1ps

// y = |a*newer - older - 0.05|, saturated to the Q3.f maximum
module cmn_map #(
  parameter int VALUE_FRAC_BITS = cmn_pkg::VALUE_FRAC_BITS_DEF
) (
  input  logic [cmn_pkg::GAIN_W-1:0]                            gain,
  input  logic [VALUE_FRAC_BITS+cmn_pkg::VAL_INT_BITS-1:0]      newer,
  input  logic [VALUE_FRAC_BITS+cmn_pkg::VAL_INT_BITS-1:0]      older,
  output logic [VALUE_FRAC_BITS+cmn_pkg::VAL_INT_BITS-1:0]      y
);

  localparam int VW = VALUE_FRAC_BITS + cmn_pkg::VAL_INT_BITS;
  localparam int PW = cmn_pkg::GAIN_W + VW;
  localparam int RW = PW - cmn_pkg::GAIN_FRAC;
  localparam int DW = VW + 3;
  localparam longint VAL_ONE  = longint'(1) << VALUE_FRAC_BITS;
  localparam longint OFFSET_K = (5 * VAL_ONE + 50) / 100;

  logic [PW-1:0]        prod_full;
  logic [PW-1:0]        prod_rnd;
  logic [RW-1:0]        prod;
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        mag;

  assign prod_full = PW'(gain) * PW'(newer);
  // round half up from Q.(f+14) to Q.f
  assign prod_rnd  = prod_full + PW'(longint'(1) << (cmn_pkg::GAIN_FRAC - 1));
  assign prod      = prod_rnd[PW-1:cmn_pkg::GAIN_FRAC];

  assign diff = $signed(DW'(prod)) - $signed(DW'(older)) - $signed(DW'(OFFSET_K));
  assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);

  assign y = (|mag[DW-1:VW]) ? {VW{1'b1}} : mag[VW-1:0];

endmodule

/* rtl/core/cmn_scale.sv */
`timescale 1ns / 1ps

// sample = floor(y * 32767 / 2^f), saturated to 32767
module cmn_scale #(
  parameter int VALUE_FRAC_BITS = cmn_pkg::VALUE_FRAC_BITS_DEF
) (
  input  logic [VALUE_FRAC_BITS+cmn_pkg::VAL_INT_BITS-1:0] y,
  output logic [cmn_pkg::SAMPLE_W-1:0]                     sample
);

  localparam int VW = VALUE_FRAC_BITS + cmn_pkg::VAL_INT_BITS;
  localparam int MW = VW + cmn_pkg::SAMPLE_W;
  localparam int SW = MW - VALUE_FRAC_BITS;

  logic [MW-1:0] scaled;
  logic [SW-1:0] shifted;

  // y * (2^15 - 1) as a shift and subtract
  assign scaled  = {y, {cmn_pkg::SAMPLE_W{1'b0}}} - MW'(y);
  assign shifted = scaled[MW-1:VALUE_FRAC_BITS];
  assign sample  = (|shifted[SW-1:cmn_pkg::SAMPLE_W]) ? cmn_pkg::SAMPLE_MAX
                                                      : shifted[cmn_pkg::SAMPLE_W-1:0];

endmodule

/* rtl/core/chaotic_map_noise_generator.sv */
`timescale 1ns / 1ps

// Crackle-map noise source. Every transfer with in_tick set yields one
// out_sample; a transfer with in_tick clear is absorbed and yields nothing.
// One tick is taken per clock cycle unless out_stall holds a pending result,
// and its sample passes the input register, then the result register. The
// rate is set by the state update loop: phase add, one 15x19 map multiply,
// subtract, abs and clamp all complete in the cycle that writes the history registers.
// Configuration applies to ticks processed after the write.
module chaotic_map_noise_generator #(
  parameter int PHASE_BITS      = cmn_pkg::PHASE_BITS_DEF,
  parameter int VALUE_FRAC_BITS = cmn_pkg::VALUE_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_tick,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [cmn_pkg::SAMPLE_W-1:0]     out_sample,
  input  logic                             cfg_we,
  input  logic [cmn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cmn_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int VW = VALUE_FRAC_BITS + cmn_pkg::VAL_INT_BITS;
  localparam int HW = VALUE_FRAC_BITS + 1;
  localparam logic [VW-1:0] VAL_ONE = VW'(longint'(1) << VALUE_FRAC_BITS);

  // configuration
  cmn_pkg::mode_t               mode_r;
  logic [cmn_pkg::INC_W-1:0]    phase_inc_r;
  logic [cmn_pkg::GAIN_W-1:0]   chaos_r;

  // state
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [VW-1:0]         first_r, first_nxt;
  logic [VW-1:0]         second_r, second_nxt;
  logic [HW-1:0]         held_r, held_nxt;

  // handshake
  logic                          s1_valid_r, s1_valid_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [cmn_pkg::SAMPLE_W-1:0]  sample_r, sample_nxt;
  logic                          s1_adv;
  logic                          in_xfer;

  logic [PHASE_BITS+cmn_pkg::INC_W-1:0] inc_ext;
  logic [PHASE_BITS:0]                  phase_sum;
  logic                                 wrap;
  logic [VW-1:0]                        map_y;
  logic [VW-1:0]                        scale_src;
  logic [cmn_pkg::SAMPLE_W-1:0]         scale_out;

  cmn_map #(
    .VALUE_FRAC_BITS(VALUE_FRAC_BITS)
  ) u_map (
    .gain  (chaos_r),
    .newer (first_r),
    .older (second_r),
    .y     (map_y)
  );

  cmn_scale #(
    .VALUE_FRAC_BITS(VALUE_FRAC_BITS)
  ) u_scale (
    .y      (scale_src),
    .sample (scale_out)
  );

  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_sample = sample_r;

  // increment masked or zero-extended to the phase width
  assign inc_ext   = {{PHASE_BITS{1'b0}}, phase_inc_r};
  assign phase_sum = {1'b0, phase_r} + {1'b0, inc_ext[PHASE_BITS-1:0]};
  assign wrap      = phase_sum[PHASE_BITS];

  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    held_nxt   = held_r;
    scale_src  = first_r;
    if (s1_adv) begin
      phase_nxt = phase_sum[PHASE_BITS-1:0];
    end
    unique case (mode_r)
      cmn_pkg::MODE_CLASSIC: begin
        if (wrap) begin
          scale_src = map_y;
        end
        if (s1_adv && wrap) begin
          second_nxt = first_r;
          first_nxt  = map_y;
        end
      end
      cmn_pkg::MODE_BROKEN: begin
        scale_src = map_y;
        if (s1_adv) begin
          if (wrap) begin
            second_nxt = first_r;
          end
          first_nxt = VW'(held_r);
          held_nxt  = (map_y > VAL_ONE) ? VAL_ONE[HW-1:0] : map_y[HW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_xfer && in_tick) begin
      s1_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r && out_stall;
    sample_nxt    = sample_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      sample_nxt    = scale_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= cmn_pkg::MODE_CLASSIC;
      phase_inc_r <= cmn_pkg::PHASE_INC_RST;
      chaos_r     <= cmn_pkg::CHAOS_RST;
      phase_r     <= '0;
      first_r     <= '0;
      second_r    <= '0;
      held_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cmn_pkg::CFG_MODE:      mode_r      <= cmn_pkg::mode_t'(cfg_data[0]);
          cmn_pkg::CFG_PHASE_INC: phase_inc_r <= cfg_data[cmn_pkg::INC_W-1:0];
          cmn_pkg::CFG_CHAOS:     chaos_r     <= cfg_data[cmn_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      phase_r     <= phase_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      held_r      <= held_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
  end

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(sample_r)))
    else $error("pending result lost or changed");

  a_held_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && mode_r == cmn_pkg::MODE_BROKEN) |=> (VW'(held_r) <= VAL_ONE))
    else $error("feedback above 1.0");
`endif

endmodule

/* bench/cmn_noise_checker.sv */
`timescale 1ns / 1ps

module cmn_noise_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_tick,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [cmn_pkg::SAMPLE_W-1:0]   out_sample,
  input  logic                           cfg_we,
  input  logic [cmn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmn_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);

  localparam int PH_W  = cmn_pkg::PHASE_BITS_DEF;
  localparam int FRAC  = cmn_pkg::VALUE_FRAC_BITS_DEF;
  localparam int VAL_W = FRAC + cmn_pkg::VAL_INT_BITS;
  localparam int SMP_W = cmn_pkg::SAMPLE_W;

  localparam longint VAL_TOP    = (longint'(1) << VAL_W) - 1;
  localparam longint ROUND_HALF = longint'(1) << (cmn_pkg::GAIN_FRAC - 1);
  // 0.05 in Q.FRAC, rounded to nearest
  localparam longint OFFSET     = (5 * (longint'(1) << FRAC) + 50) / 100;
  localparam logic [VAL_W-1:0] VAL_ONE = VAL_W'(1) << FRAC;

  cmn_pkg::mode_t            cur_mode;
  logic [cmn_pkg::INC_W-1:0] phase_step;
  logic [cmn_pkg::GAIN_W-1:0] gain;

  logic [PH_W-1:0]  phase_acc;
  logic [VAL_W-1:0] hist_new;
  logic [VAL_W-1:0] hist_old;
  logic [FRAC:0]    feedback;

  logic [SMP_W-1:0] expected_samples[$];

  // y = |a*newer - older - 0.05|, saturated to Q3.FRAC
  function automatic logic [VAL_W-1:0] crackle_map(input logic [VAL_W-1:0] newer,
                                                   input logic [VAL_W-1:0] older);
    longint scaled;
    longint diff;
    scaled = (longint'(gain) * longint'(newer) + ROUND_HALF) >>> cmn_pkg::GAIN_FRAC;
    diff = scaled - longint'(older) - OFFSET;
    if (diff < 0) diff = -diff;
    if (diff > VAL_TOP) diff = VAL_TOP;
    return diff[VAL_W-1:0];
  endfunction

  function automatic logic [SMP_W-1:0] level_to_sample(input logic [VAL_W-1:0] y);
    longint s;
    s = (longint'(y) * longint'(cmn_pkg::SAMPLE_MAX)) >>> FRAC;
    if (s > longint'(cmn_pkg::SAMPLE_MAX)) s = longint'(cmn_pkg::SAMPLE_MAX);
    return s[SMP_W-1:0];
  endfunction

  function automatic logic [SMP_W-1:0] advance_tick();
    logic [PH_W:0]    sum;
    logic             wrap;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] clamped;
    logic [SMP_W-1:0] s;
    sum = {1'b0, phase_acc} + {1'b0, phase_step[PH_W-1:0]};
    wrap = sum[PH_W];
    phase_acc = sum[PH_W-1:0];
    if (cur_mode == cmn_pkg::MODE_CLASSIC) begin
      if (wrap) begin
        y = crackle_map(hist_new, hist_old);
        hist_old = hist_new;
        hist_new = y;
      end
      s = level_to_sample(hist_new);
    end else begin
      y = crackle_map(hist_new, hist_old);
      if (wrap) hist_old = hist_new;
      // one-tick-delayed feedback, clamped to 1.0
      hist_new = {{(VAL_W-FRAC-1){1'b0}}, feedback};
      clamped = (y > VAL_ONE) ? VAL_ONE : y;
      feedback = clamped[FRAC:0];
      s = level_to_sample(y);
    end
    return s;
  endfunction

  always @(posedge clk) begin : watch
    logic [SMP_W-1:0] want;
    if (!rst_n) begin
      expected_samples.delete();
      cur_mode = cmn_pkg::MODE_CLASSIC;
      phase_step = cmn_pkg::PHASE_INC_RST;
      gain = cmn_pkg::CHAOS_RST;
      phase_acc = '0;
      hist_new = '0;
      hist_old = '0;
      feedback = '0;
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: out_sample expected none, got %0d", $time, out_sample);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want) begin
            $display("%0t: out_sample expected %0d, got %0d", $time, want, out_sample);
            fail_count <= fail_count + 1;
          end
          checked <= checked + 1;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          cmn_pkg::CFG_MODE:      cur_mode = cmn_pkg::mode_t'(cfg_data[0]);
          cmn_pkg::CFG_PHASE_INC: phase_step = cfg_data[cmn_pkg::INC_W-1:0];
          cmn_pkg::CFG_CHAOS:     gain = cfg_data[cmn_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      // a transfer with tick clear leaves the state alone
      if (in_valid && !in_stall && in_tick)
        expected_samples.push_back(advance_tick());
    end
    pending <= expected_samples.size();
  end

endmodule

/* bench/tb_chaotic_map_noise_generator.sv */
`timescale 1ns / 1ps

module tb_chaotic_map_noise_generator;

  localparam int IDX_W  = cmn_pkg::CFG_IDX_W;
  localparam int DATA_W = cmn_pkg::CFG_DATA_W;

  localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 430;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 6;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_tick;
  logic out_valid;
  logic out_stall;
  logic [cmn_pkg::SAMPLE_W-1:0] out_sample;
  logic cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int cycles = 0;
  int ticks_sent = 0;
  int idle_sent = 0;
  int settings = 0;
  bit no_gaps = 1'b0;

  chaotic_map_noise_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_tick    (in_tick),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cmn_noise_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_tick    (in_tick),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d samples still outstanding", $time, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // mostly short runs, now and then a long one
  function automatic int burst_len(input bit longer);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return longer ? $urandom_range(40, 200) : $urandom_range(20, 60);
  endfunction

  // receiver backpressure: alternating stall and free stretches, one update per edge
  initial begin
    int left;
    left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (left > 0) begin
        left--;
      end else if (out_stall) begin
        out_stall <= 1'b0;
        left = burst_len(1'b1) - 1;
      end else begin
        out_stall <= 1'b1;
        left = burst_len(1'b0) - 1;
      end
    end
  end

  task automatic send_item(input logic tick);
    int gap;
    gap = (no_gaps || $urandom_range(0, 99) < 45) ? 0 : burst_len(1'b0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tick <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (tick) ticks_sent++;
    else idle_sent++;
  endtask

  // wait until every expected sample has been taken, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_settings();
    logic [DATA_W-1:0] inc;
    logic [DATA_W-1:0] gain;
    case ($urandom_range(0, 5))
      0:       inc = '0;
      1:       inc = 24'hFFFFFF;
      2:       inc = 24'h800000;
      3:       inc = DATA_W'($urandom_range(0, 65535));
      default: inc = DATA_W'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       gain = '0;
      1:       gain = 24'h007FFF;
      2:       gain = DATA_W'($urandom);
      default: gain = DATA_W'($urandom_range(16384, 32767));
    endcase
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, DATA_W'($urandom));
    // upper bits of the mode word are don't-care
    write_reg(cmn_pkg::CFG_MODE, DATA_W'($urandom));
    write_reg(cmn_pkg::CFG_PHASE_INC, inc);
    write_reg(cmn_pkg::CFG_CHAOS, gain);
    settings++;
  endtask

  initial begin
    int n;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_tick <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= cmn_pkg::CFG_MODE;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: wrap on every fourth tick, idle inputs mixed in
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);

    // ignored index and oversized data, then near-continuous wraps at max gain
    drain();
    write_reg(CFG_UNUSED, 24'hFFFFFF);
    write_reg(cmn_pkg::CFG_MODE, 24'hFFFFFE);
    write_reg(cmn_pkg::CFG_CHAOS, 24'hFFFFFF);
    write_reg(cmn_pkg::CFG_PHASE_INC, 24'hFFFFFF);
    settings++;
    repeat (4) send_item(1'b1);

    // broken mode, no wraps, max gain: feedback grows until the sample saturates
    drain();
    write_reg(cmn_pkg::CFG_MODE, 24'h000001);
    write_reg(cmn_pkg::CFG_PHASE_INC, 24'h000000);
    write_reg(cmn_pkg::CFG_CHAOS, 24'h007FFF);
    settings++;
    repeat (10) send_item(1'b1);

    // back to classic with zero gain, history kept from broken mode
    drain();
    write_reg(cmn_pkg::CFG_CHAOS, 24'h000000);
    write_reg(cmn_pkg::CFG_MODE, 24'h000000);
    write_reg(cmn_pkg::CFG_PHASE_INC, 24'h800000);
    settings++;
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);

    while (ticks_sent + idle_sent < ITEM_TARGET) begin
      drain();
      random_settings();
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(30, 70);
      repeat (n) send_item($urandom_range(0, 99) >= 12);
    end
    no_gaps = 1'b0;
    drain();

    $display("Run covered %0d ticks and %0d idle transfers over %0d register settings.",
             ticks_sent, idle_sent, settings);
    $display("Compared %0d samples in both modes, incl. gain/increment extremes.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
